### hw/rtl/vppr_pkg.sv
// Shared types and constants for the video payload pixel remapper.
`timescale 1ns / 1ps

package vppr_pkg;

    // Pixel map geometry
    localparam int MAP_DEPTH = 4096;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    // Field widths
    localparam int SIZE_W    = 13;
    localparam int COUNTER_W = 13;
    localparam int SUM_W     = 22;
    localparam int ENTRY_W   = 16;
    localparam int ADDR_W    = 15;

    localparam logic [COUNTER_W-1:0] COUNTER_MAX = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX     = '1;

    // Input opcodes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_EOF    = 2'd1;
    localparam logic [1:0] OP_MAP_WR = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_SUM   = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         payload_byte;
        logic               packet_start;
        logic [11:0]        map_index;
        logic signed [15:0] map_value;
    } in_word_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        out_byte_a;
        logic [7:0]        out_byte_b;
        logic [7:0]        out_byte_c;
        logic [SUM_W-1:0]  frame_sum;
    } out_word_t;

    // Events passed from the grouping stage to the emit stage
    typedef enum logic [1:0] {
        EV_PIXEL,
        EV_EOF,
        EV_CLEAR
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic       in_range;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } pix_event_t;

endpackage

### hw/rtl/video_payload_pixel_remapper.sv
// Top level of the video payload pixel remapper.
// Results pass the group event register, then the emit output register.
// One input word per cycle while in_ready; map read is issued on acceptance.
// Stalls on out_ready propagate back to in_ready through a single event stage.
// Reset clears all control state and map_size; map contents stay undefined
// until written.
`timescale 1ns / 1ps

module video_payload_pixel_remapper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [vppr_pkg::SIZE_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vppr_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vppr_pkg::out_word_t           out_word
);
    import vppr_pkg::*;

    logic               accept;
    logic               ev_valid;
    logic               ev_take;
    pix_event_t         ev;
    logic               map_wr_en;
    logic [MAP_AW-1:0]  map_wr_addr;
    logic [ENTRY_W-1:0] map_wr_data;
    logic               map_rd_en;
    logic [MAP_AW-1:0]  map_rd_addr;
    logic [ENTRY_W-1:0] map_rd_data;

    // event stage frees up when empty or drained this cycle
    assign in_ready = !ev_valid || ev_take;
    assign accept   = in_valid && in_ready;

    vppr_group u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_word     (in_word),
        .ev_take     (ev_take),
        .ev_valid    (ev_valid),
        .ev          (ev),
        .map_wr_en   (map_wr_en),
        .map_wr_addr (map_wr_addr),
        .map_wr_data (map_wr_data),
        .map_rd_en   (map_rd_en),
        .map_rd_addr (map_rd_addr)
    );

    vppr_map u_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    vppr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_valid    (ev_valid),
        .ev          (ev),
        .map_rd_data (map_rd_data),
        .ev_take     (ev_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

endmodule

### hw/rtl/vppr_map.sv
// Pixel map memory: one write port, one registered read port.
`timescale 1ns / 1ps

module vppr_map (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [vppr_pkg::MAP_AW-1:0]          wr_addr,
    input  logic [vppr_pkg::ENTRY_W-1:0]         wr_data,
    input  logic                                 rd_en,
    input  logic [vppr_pkg::MAP_AW-1:0]          rd_addr,
    output logic [vppr_pkg::ENTRY_W-1:0]         rd_data
);
    import vppr_pkg::*;

    logic [ENTRY_W-1:0] mem [MAP_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/vppr_group.sv
// Header skip, byte-to-pixel grouping, pixel counter and map read issue.
`timescale 1ns / 1ps

module vppr_group (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [vppr_pkg::SIZE_W-1:0]          cfg_wr_data,
    input  logic                                 accept,
    input  vppr_pkg::in_word_t                   in_word,
    input  logic                                 ev_take,
    output logic                                 ev_valid,
    output vppr_pkg::pix_event_t                 ev,
    output logic                                 map_wr_en,
    output logic [vppr_pkg::MAP_AW-1:0]          map_wr_addr,
    output logic [vppr_pkg::ENTRY_W-1:0]         map_wr_data,
    output logic                                 map_rd_en,
    output logic [vppr_pkg::MAP_AW-1:0]          map_rd_addr
);
    import vppr_pkg::*;

    logic [SIZE_W-1:0]    map_size_reg;
    logic [15:0]          held_bytes_reg, held_bytes_next;
    logic [1:0]           held_count_reg, held_count_next;
    logic [COUNTER_W-1:0] pixel_counter_reg, pixel_counter_next;
    logic                 header_skip_reg, header_skip_next;
    logic                 next_is_first_reg, next_is_first_next;
    logic                 ev_valid_reg, ev_valid_next;
    pix_event_t           ev_reg, ev_next;
    logic                 ev_load;
    logic                 in_range;

    // map size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            map_size_reg <= cfg_wr_data;
        end
    end

    // pixel index bound check
    assign in_range = (pixel_counter_reg < map_size_reg) &&
                      (32'(pixel_counter_reg) < MAP_DEPTH);

    // map table writes
    assign map_wr_en   = accept && (in_word.opcode == OP_MAP_WR) &&
                         (32'(in_word.map_index) < MAP_DEPTH);
    assign map_wr_addr = MAP_AW'(in_word.map_index);
    assign map_wr_data = in_word.map_value;

    // next state and event decode
    always_comb
    begin
        held_bytes_next    = held_bytes_reg;
        held_count_next    = held_count_reg;
        pixel_counter_next = pixel_counter_reg;
        header_skip_next   = header_skip_reg;
        next_is_first_next = next_is_first_reg;
        ev_load            = 1'b0;
        ev_next.kind       = EV_PIXEL;
        ev_next.in_range   = in_range;
        ev_next.byte0      = held_bytes_reg[7:0];
        ev_next.byte1      = held_bytes_reg[15:8];
        ev_next.byte2      = in_word.payload_byte;
        map_rd_en          = 1'b0;
        map_rd_addr        = MAP_AW'(pixel_counter_reg);

        if (accept)
        begin
            unique case (in_word.opcode)
                OP_EOF:
                begin
                    held_count_next    = 2'd0;
                    held_bytes_next    = '0;
                    next_is_first_next = 1'b1;
                    ev_load            = 1'b1;
                    ev_next.kind       = EV_EOF;
                end
                OP_BYTE:
                begin
                    priority if (in_word.packet_start && next_is_first_reg)
                    begin
                        // frame start: drop this byte, and the next unless it starts a packet
                        next_is_first_next = 1'b0;
                        pixel_counter_next = '0;
                        held_count_next    = 2'd0;
                        held_bytes_next    = '0;
                        header_skip_next   = 1'b1;
                        ev_load            = 1'b1;
                        ev_next.kind       = EV_CLEAR;
                    end
                    else if (!in_word.packet_start && header_skip_reg)
                    begin
                        header_skip_next = 1'b0;
                    end
                    else
                    begin
                        header_skip_next = 1'b0;
                        if (held_count_reg == 2'd0)
                        begin
                            held_bytes_next = {8'd0, in_word.payload_byte};
                            held_count_next = 2'd1;
                        end
                        else if (held_count_reg == 2'd1)
                        begin
                            held_bytes_next = {in_word.payload_byte, held_bytes_reg[7:0]};
                            held_count_next = 2'd2;
                        end
                        else
                        begin
                            // third byte completes a pixel
                            held_count_next = 2'd0;
                            ev_load         = 1'b1;
                            ev_next.kind    = EV_PIXEL;
                            map_rd_en       = in_range;
                            if (pixel_counter_reg != COUNTER_MAX)
                            begin
                                pixel_counter_next = pixel_counter_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // map writes handled above, unused opcode ignored
                end
            endcase
        end

        ev_valid_next = ev_load ? 1'b1 : (ev_take ? 1'b0 : ev_valid_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg    <= '0;
            held_count_reg    <= 2'd0;
            pixel_counter_reg <= '0;
            header_skip_reg   <= 1'b0;
            next_is_first_reg <= 1'b0;
            ev_valid_reg      <= 1'b0;
        end
        else
        begin
            held_bytes_reg    <= held_bytes_next;
            held_count_reg    <= held_count_next;
            pixel_counter_reg <= pixel_counter_next;
            header_skip_reg   <= header_skip_next;
            next_is_first_reg <= next_is_first_next;
            ev_valid_reg      <= ev_valid_next;
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (ev_load)
        begin
            ev_reg <= ev_next;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

### hw/rtl/vppr_emit.sv
// Frame sum accumulation and output word register.
`timescale 1ns / 1ps

module vppr_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ev_valid,
    input  vppr_pkg::pix_event_t          ev,
    input  logic [vppr_pkg::ENTRY_W-1:0]  map_rd_data,
    output logic                          ev_take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vppr_pkg::out_word_t           out_word
);
    import vppr_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_word_reg, out_word_next;
    logic             mapped;
    logic             has_out;
    logic [SUM_W:0]   sum_wide;

    // a pixel is written only when in range and its entry is not negative
    assign mapped   = (ev.kind == EV_PIXEL) && ev.in_range && !map_rd_data[ENTRY_W-1];
    assign has_out  = mapped || (ev.kind == EV_EOF);
    assign ev_take  = ev_valid && (!has_out || !out_valid_reg || out_ready);
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(ev.byte0) +
                      (SUM_W+1)'(ev.byte1) + (SUM_W+1)'(ev.byte2);

    // sum update and result build
    always_comb
    begin
        sum_next                    = sum_reg;
        out_word_next.kind          = KIND_PIXEL;
        out_word_next.write_address = '0;
        out_word_next.out_byte_a    = '0;
        out_word_next.out_byte_b    = '0;
        out_word_next.out_byte_c    = '0;
        out_word_next.frame_sum     = '0;

        unique case (ev.kind)
            EV_CLEAR:
            begin
                sum_next = '0;
            end
            EV_EOF:
            begin
                out_word_next.kind      = KIND_SUM;
                out_word_next.frame_sum = sum_reg;
            end
            EV_PIXEL:
            begin
                if (mapped)
                begin
                    sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                end
                out_word_next.write_address = map_rd_data[ADDR_W-1:0];
                out_word_next.out_byte_a    = ev.byte1;
                out_word_next.out_byte_b    = ev.byte2;
                out_word_next.out_byte_c    = ev.byte0;
            end
            default:
            begin
            end
        endcase

        if (ev_take && has_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_take)
            begin
                sum_reg <= sum_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (ev_take && has_out)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
